// ===== hw/rtl/sblr_pkg.sv =====
// Shared types and constants for the spectrum band log reducer.
package sblr_pkg;

  // Band table geometry
  localparam int unsigned MAX_BANDS = 32;
  localparam int unsigned BAND_W    = $clog2(MAX_BANDS);
  localparam int unsigned CNT_W     = BAND_W + 1;
  localparam int unsigned SPAN_W    = 8;
  localparam int unsigned FILL_W    = SPAN_W;

  // Sample and result widths
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned LVL_W     = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // Log unit: x in [1,2) with 32 fraction bits, accumulator with 48 fraction bits
  localparam int unsigned X_W       = 33;
  localparam int unsigned SQ_W      = 2 * X_W;
  localparam int unsigned EXP_W     = $clog2(MAG_W);
  localparam int unsigned FRAC_W    = 48;
  localparam int unsigned P_W       = 13;
  localparam int unsigned ACC_W     = FRAC_W + P_W;
  localparam int unsigned LOG_STEPS = 40;
  localparam int unsigned STEP_W    = $clog2(LOG_STEPS + 1);

  // 1000*log10(2) scaled by 2^48
  localparam logic [ACC_W-1:0] LOG_C    = ACC_W'(64'd84732411018727984);
  // Small upward nudge (2^-21) that covers the truncation loss of the squaring loop
  localparam logic [ACC_W-1:0] LOG_BIAS = ACC_W'(64'd134217728);

  // Scaling arithmetic
  localparam int unsigned BOUND_W   = 14;
  localparam int unsigned NUM_W     = BOUND_W + LVL_W - 1;
  localparam int unsigned PROD_W    = BOUND_W + LVL_W;
  localparam int unsigned DSTEP_W   = $clog2(LVL_W);

  // Op codes of an input beat
  localparam logic OP_SPAN_WRITE = 1'b0;
  localparam logic OP_SAMPLE     = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_COUNT = 2'd0,
    CFG_FLOOR      = 2'd1,
    CFG_CEILING    = 2'd2,
    CFG_SCALE      = 2'd3
  } cfg_idx_e;

  // Level mapping settings handed to the level unit
  typedef struct packed {
    logic [CFG_W-1:0] floor_lvl;
    logic [CFG_W-1:0] ceil_lvl;
    logic [LVL_W-1:0] scale;
  } cfg_t;

endpackage

// ===== hw/rtl/sblr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sblr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sblr_level.sv =====
// Band level unit: exact-floor 1000*log10 of a peak, then range mapping and division.
module sblr_level (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sblr_pkg::MAG_W-1:0]  peak_i,
  input  sblr_pkg::cfg_t              cfg_i,
  output logic                        done_o,
  output logic [sblr_pkg::LVL_W-1:0]  level_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_LOG,
    L_SCALE,
    L_DIV
  } lstate_e;

  lstate_e                          state_q, state_d;
  logic [sblr_pkg::X_W-1:0]         x_q, x_d;
  logic [sblr_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic [sblr_pkg::ACC_W-1:0]       cs_q, cs_d;
  logic                             bit_q, bit_d;
  logic [sblr_pkg::STEP_W-1:0]      step_q, step_d;
  logic [sblr_pkg::NUM_W-1:0]       rem_q, rem_d;
  logic [sblr_pkg::NUM_W-1:0]       ds_q, ds_d;
  logic [sblr_pkg::LVL_W-1:0]       quo_q, quo_d;
  logic [sblr_pkg::DSTEP_W-1:0]     dstep_q, dstep_d;
  logic                             done_q, done_d;
  logic [sblr_pkg::LVL_W-1:0]       level_q, level_d;

  logic [sblr_pkg::EXP_W-1:0]       msb;
  logic [5:0]                       shamt;
  logic [sblr_pkg::X_W-1:0]         x_ext;
  logic [sblr_pkg::ACC_W-1:0]       acc_init;
  logic [sblr_pkg::SQ_W-1:0]        sq;
  logic [sblr_pkg::BOUND_W-1:0]     p_ext;
  logic [sblr_pkg::BOUND_W-1:0]     lo;
  logic [sblr_pkg::BOUND_W-1:0]     hi;
  logic [sblr_pkg::BOUND_W-1:0]     hl_diff;
  logic [sblr_pkg::BOUND_W-1:0]     pl_diff;
  logic                             ge;

  // Position of the leading one of the peak
  always_comb begin
    msb = '0;
    for (int i = 0; i < sblr_pkg::MAG_W; i++) begin
      if (peak_i[i]) begin
        msb = sblr_pkg::EXP_W'(i);
      end
    end
  end

  // Normalized mantissa and integer part of the log, already weighted by 1000*log10(2)
  always_comb begin
    shamt    = 6'(sblr_pkg::X_W - 1) - 6'(msb);
    x_ext    = sblr_pkg::X_W'(peak_i);
    acc_init = sblr_pkg::LOG_BIAS;
    for (int b = 0; b < sblr_pkg::EXP_W; b++) begin
      if (msb[b]) begin
        acc_init = acc_init + (sblr_pkg::LOG_C << b);
      end
    end
  end

  // One squaring per cycle yields one fraction bit of log2
  assign sq = sblr_pkg::SQ_W'(x_q) * sblr_pkg::SQ_W'(x_q);

  // Range bounds in tenths
  assign p_ext   = sblr_pkg::BOUND_W'(acc_q[sblr_pkg::ACC_W-1:sblr_pkg::FRAC_W]);
  assign lo      = sblr_pkg::BOUND_W'(cfg_i.floor_lvl) * sblr_pkg::BOUND_W'(10);
  assign hi      = sblr_pkg::BOUND_W'(cfg_i.ceil_lvl) * sblr_pkg::BOUND_W'(10);
  assign hl_diff = hi - lo;
  assign pl_diff = p_ext - lo;
  assign ge      = (rem_q >= ds_q);

  // Sequencer: log, scale, then restoring divide
  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    acc_d   = acc_q;
    cs_d    = cs_q;
    bit_d   = bit_q;
    step_d  = step_q;
    rem_d   = rem_q;
    ds_d    = ds_q;
    quo_d   = quo_q;
    dstep_d = dstep_q;
    done_d  = 1'b0;
    level_d = level_q;
    case (state_q)
      L_IDLE: begin
        if (start_i) begin
          if (peak_i == '0) begin
            done_d  = 1'b1;
            level_d = '0;
          end else begin
            x_d     = x_ext << shamt;
            acc_d   = acc_init;
            cs_d    = sblr_pkg::LOG_C;
            bit_d   = 1'b0;
            step_d  = '0;
            state_d = L_LOG;
          end
        end
      end
      L_LOG: begin
        // the bit found last cycle is added with its weight now
        acc_d  = acc_q + (bit_q ? cs_q : '0);
        cs_d   = cs_q >> 1;
        bit_d  = sq[sblr_pkg::SQ_W-1];
        x_d    = sq[sblr_pkg::SQ_W-1] ? sq[sblr_pkg::SQ_W-1 -: sblr_pkg::X_W]
                                      : sq[sblr_pkg::SQ_W-2 -: sblr_pkg::X_W];
        step_d = step_q + 1'b1;
        if (step_q == sblr_pkg::STEP_W'(sblr_pkg::LOG_STEPS)) begin
          state_d = L_SCALE;
        end
      end
      L_SCALE: begin
        if (p_ext < lo) begin
          done_d  = 1'b1;
          level_d = '0;
          state_d = L_IDLE;
        end else if (p_ext > hi) begin
          done_d  = 1'b1;
          level_d = cfg_i.scale;
          state_d = L_IDLE;
        end else if (hi == lo) begin
          done_d  = 1'b1;
          level_d = '0;
          state_d = L_IDLE;
        end else begin
          rem_d   = sblr_pkg::NUM_W'(sblr_pkg::PROD_W'(pl_diff)
                                     * sblr_pkg::PROD_W'(cfg_i.scale));
          ds_d    = {hl_diff, {(sblr_pkg::LVL_W-1){1'b0}}};
          quo_d   = '0;
          dstep_d = '0;
          state_d = L_DIV;
        end
      end
      L_DIV: begin
        // quotient fits LVL_W bits since the numerator stays below divisor * 2^LVL_W
        rem_d   = ge ? (rem_q - ds_q) : rem_q;
        quo_d   = {quo_q[sblr_pkg::LVL_W-2:0], ge};
        ds_d    = ds_q >> 1;
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == sblr_pkg::DSTEP_W'(sblr_pkg::LVL_W - 1)) begin
          done_d  = 1'b1;
          level_d = {quo_q[sblr_pkg::LVL_W-2:0], ge};
          state_d = L_IDLE;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
      dstep_q <= '0;
      bit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
      dstep_q <= dstep_d;
      bit_q   <= bit_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    acc_q   <= acc_d;
    cs_q    <= cs_d;
    rem_q   <= rem_d;
    ds_q    <= ds_d;
    quo_q   <= quo_d;
    level_q <= level_d;
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

// ===== hw/rtl/spectrum_band_log_reducer.sv =====
// Spectrum band log reducer top level: band sequencer, span table, level unit, configuration
// registers and output register.
//
// Magnitude samples of a frame are grouped into bands whose widths sit in a 32-entry span
// table (entries read as one until written); each finished band yields one result beat with
// level = scale mapping of floor(1000*log10(peak)). A sample that finishes no band passes
// through accept, span table read, evaluate and bookkeeping; an ignored sample (no bands,
// frame already done) goes from accept straight to bookkeeping. A band that completes also
// runs the level unit (start, the squaring log loop on a single 33x33 multiplier, a mapping
// step, a restoring divide and the done handoff), an emit and a table read of the next band.
// A peak outside the bounds skips the divide and a zero peak skips the log loop as well.
// Zero-span bands and bands flushed as zero at an early frame end skip the level unit; every
// emit also waits out result stalls. No input beat is taken while an item is in work; a
// stalled result waits in the output register.
module spectrum_band_log_reducer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [sblr_pkg::BAND_W-1:0]     band_slot_i,
  input  logic [sblr_pkg::SPAN_W-1:0]     band_span_i,
  input  logic [sblr_pkg::MAG_W-1:0]      magnitude_i,
  input  logic                            frame_end_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sblr_pkg::BAND_W-1:0]     band_number_o,
  output logic [sblr_pkg::LVL_W-1:0]      level_o,
  output logic                            final_band_o,
  // configuration port
  input  logic                            cfg_we_i,
  input  logic [sblr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sblr_pkg::CFG_W-1:0]      cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LEVEL,
    S_EMIT,
    S_END
  } state_e;

  state_e                            state_q, state_d;
  logic [sblr_pkg::CNT_W-1:0]        cur_q, cur_d;
  logic [sblr_pkg::FILL_W-1:0]       fill_q, fill_d;
  logic [sblr_pkg::MAG_W-1:0]        peak_q, peak_d;
  logic                              done_q, done_d;
  logic [sblr_pkg::MAG_W-1:0]        mag_q, mag_d;
  logic                              end_q, end_d;
  logic                              consumed_q, consumed_d;
  logic                              flush_q, flush_d;
  logic [sblr_pkg::LVL_W-1:0]        lvl_q, lvl_d;
  logic                              lvl_start_q, lvl_start_d;
  logic [sblr_pkg::MAX_BANDS-1:0]    vld_q, vld_d;
  logic                              rd_vld_q, rd_vld_d;
  logic                              out_valid_q, out_valid_d;
  logic [sblr_pkg::BAND_W-1:0]       out_band_q, out_band_d;
  logic [sblr_pkg::LVL_W-1:0]        out_level_q, out_level_d;
  logic                              out_final_q, out_final_d;

  logic [sblr_pkg::CNT_W-1:0]        band_count_q;
  sblr_pkg::cfg_t                    cfg_q;

  logic [sblr_pkg::CNT_W-1:0]        count;
  logic [sblr_pkg::CNT_W-1:0]        cur_inc;
  logic                              next_lt;
  logic                              out_free;
  logic [sblr_pkg::SPAN_W-1:0]       span;
  logic [sblr_pkg::SPAN_W-1:0]       ram_rdata;
  logic                              ram_we;
  logic                              ram_re;
  logic [sblr_pkg::FILL_W-1:0]       fill_inc;
  logic                              do_emit;
  logic                              do_adv;
  logic [sblr_pkg::LVL_W-1:0]        emit_level;
  logic                              lvl_done;
  logic [sblr_pkg::LVL_W-1:0]        lvl_result;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q    <= '0;
      cfg_q.floor_lvl <= sblr_pkg::CFG_W'(100);
      cfg_q.ceil_lvl  <= sblr_pkg::CFG_W'(300);
      cfg_q.scale     <= '0;
    end else if (cfg_we_i) begin
      case (sblr_pkg::cfg_idx_e'(cfg_index_i))
        sblr_pkg::CFG_BAND_COUNT: band_count_q    <= cfg_wdata_i[sblr_pkg::CNT_W-1:0];
        sblr_pkg::CFG_FLOOR:      cfg_q.floor_lvl <= cfg_wdata_i;
        sblr_pkg::CFG_CEILING:    cfg_q.ceil_lvl  <= cfg_wdata_i;
        sblr_pkg::CFG_SCALE:      cfg_q.scale     <= cfg_wdata_i[sblr_pkg::LVL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Bands in use, clamped to the table depth
  assign count = (band_count_q > sblr_pkg::CNT_W'(sblr_pkg::MAX_BANDS))
               ? sblr_pkg::CNT_W'(sblr_pkg::MAX_BANDS) : band_count_q;

  assign cur_inc  = cur_q + 1'b1;
  assign next_lt  = (cur_inc < count);
  assign out_free = !out_valid_q || !out_stall_i;
  assign fill_inc = fill_q + 1'b1;
  // unwritten table entries read as one
  assign span     = rd_vld_q ? ram_rdata : sblr_pkg::SPAN_W'(1);

  // Span table
  sblr_ram #(
    .WIDTH (sblr_pkg::SPAN_W),
    .DEPTH (sblr_pkg::MAX_BANDS)
  ) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (band_slot_i),
    .wdata_i (band_span_i),
    .re_i    (ram_re),
    .raddr_i (cur_q[sblr_pkg::BAND_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Level unit
  sblr_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lvl_start_q),
    .peak_i  (peak_q),
    .cfg_i   (cfg_q),
    .done_o  (lvl_done),
    .level_o (lvl_result)
  );

  // Band sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    fill_d      = fill_q;
    peak_d      = peak_q;
    done_d      = done_q;
    mag_d       = mag_q;
    end_d       = end_q;
    consumed_d  = consumed_q;
    flush_d     = flush_q;
    lvl_d       = lvl_q;
    lvl_start_d = 1'b0;
    vld_d       = vld_q;
    rd_vld_d    = rd_vld_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    do_emit     = 1'b0;
    do_adv      = 1'b0;
    emit_level  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == sblr_pkg::OP_SPAN_WRITE) begin
            ram_we             = 1'b1;
            vld_d[band_slot_i] = 1'b1;
          end else begin
            mag_d      = magnitude_i;
            end_d      = frame_end_i;
            consumed_d = 1'b0;
            if ((count != '0) && !done_q && (cur_q < count)) begin
              state_d = S_READ;
            end else begin
              state_d = S_END;
            end
          end
        end
      end
      S_READ: begin
        ram_re   = 1'b1;
        rd_vld_d = vld_q[cur_q[sblr_pkg::BAND_W-1:0]];
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (span == '0) begin
          // empty band: report zero and move on
          if (out_free) begin
            do_emit = 1'b1;
            do_adv  = 1'b1;
            if (next_lt) begin
              state_d = S_READ;
            end else begin
              done_d  = 1'b1;
              state_d = S_END;
            end
          end
        end else if (!consumed_q) begin
          peak_d     = (mag_q > peak_q) ? mag_q : peak_q;
          fill_d     = fill_inc;
          consumed_d = 1'b1;
          if (fill_inc >= span) begin
            lvl_start_d = 1'b1;
            flush_d     = 1'b0;
            state_d     = S_LEVEL;
          end else begin
            state_d = S_END;
          end
        end else begin
          state_d = S_END;
        end
      end
      S_LEVEL: begin
        if (lvl_done) begin
          lvl_d   = lvl_result;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          do_emit    = 1'b1;
          emit_level = lvl_q;
          do_adv     = 1'b1;
          if (flush_q) begin
            state_d = S_END;
          end else if (next_lt) begin
            state_d = S_READ;
          end else begin
            done_d  = 1'b1;
            state_d = S_END;
          end
        end
      end
      S_END: begin
        if (end_q && (count != '0) && !done_q && (cur_q < count)) begin
          // early frame end: partial band from its peak, later bands as zero
          if (fill_q != '0) begin
            lvl_start_d = 1'b1;
            flush_d     = 1'b1;
            state_d     = S_LEVEL;
          end else if (out_free) begin
            do_emit = 1'b1;
            do_adv  = 1'b1;
          end
        end else begin
          if (end_q) begin
            cur_d  = '0;
            fill_d = '0;
            peak_d = '0;
            done_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Advance to the next band
    if (do_adv) begin
      cur_d  = cur_inc;
      fill_d = '0;
      peak_d = '0;
    end

    // Output register
    out_valid_d = out_valid_q && out_stall_i;
    out_band_d  = out_band_q;
    out_level_d = out_level_q;
    out_final_d = out_final_q;
    if (do_emit) begin
      out_valid_d = 1'b1;
      out_band_d  = cur_q[sblr_pkg::BAND_W-1:0];
      out_level_d = emit_level;
      out_final_d = (cur_inc == count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      fill_q      <= '0;
      peak_q      <= '0;
      done_q      <= 1'b0;
      end_q       <= 1'b0;
      consumed_q  <= 1'b0;
      flush_q     <= 1'b0;
      lvl_start_q <= 1'b0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      fill_q      <= fill_d;
      peak_q      <= peak_d;
      done_q      <= done_d;
      end_q       <= end_d;
      consumed_q  <= consumed_d;
      flush_q     <= flush_d;
      lvl_start_q <= lvl_start_d;
      vld_q       <= vld_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    lvl_q       <= lvl_d;
    out_band_q  <= out_band_d;
    out_level_q <= out_level_d;
    out_final_q <= out_final_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign band_number_o = out_band_q;
  assign level_o       = out_level_q;
  assign final_band_o  = out_final_q;

endmodule
